// ===== hw/rtl/dfpb_pkg.sv =====
// Package for the deduplicating FIFO packet buffer.
// Request, response and stored-entry types, command codes and defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dfpb_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int LIMIT_W   = 5;
    localparam int MATCH_W   = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd16;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_FWD   = 2'd1,
        CMD_COUNT = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] source;
        logic [15:0] destination;
        logic [31:0] timestamp;
        logic [31:0] start_time;
        logic [31:0] end_time;
    } t_req;

    typedef struct packed {
        logic               accepted;
        logic               packet_valid;
        logic [15:0]        out_source;
        logic [15:0]        out_destination;
        logic [31:0]        out_timestamp;
        logic [MATCH_W-1:0] match_count;
    } t_rsp;

    typedef struct packed {
        logic [15:0] source;
        logic [15:0] destination;
        logic [31:0] timestamp;
    } t_entry;

endpackage
`default_nettype wire

// ===== hw/rtl/dedup_fifo_packet_buffer_unit.sv =====
// Deduplicating FIFO packet buffer, top level.
// Packet ring in one synchronous memory, scanned one entry per cycle.
// Depends on dfpb_pkg.
//
//  channel | direction | handshake                | payload
//  in      | input     | i_in_valid / o_in_ready  | i_in  (t_req)
//  out     | output    | o_out_valid / i_out_ready| o_out (t_rsp)
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_data (memory limit)
//
// One request at a time: add and count read every stored entry, forward only
// the head entry (none when empty), an unused code none; the single memory
// read port scans the ring.
// Synchronous active-low reset empties the ring and sets the limit to 16.
// A new request is taken while a finished response waits in the output
// register; the request then holds in its final step until that drains.
`timescale 1ns / 1ps
`default_nettype none
module dedup_fifo_packet_buffer_unit
    import dfpb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_req               i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_rsp                    o_out,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [LIMIT_W-1:0] i_cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW = $clog2(DEPTH + 1);
    localparam int CW = (OW > LIMIT_W) ? OW : LIMIT_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state, n_state;
    t_req               r_req;
    t_entry             r_mem [DEPTH];
    t_entry             r_rd_data;
    t_entry             r_fwd;
    logic               r_rd_vld;
    logic [AW-1:0]      r_head, r_tail, r_ptr;
    logic [OW-1:0]      r_occ, r_left;
    logic               r_dup;
    logic [MATCH_W-1:0] r_cnt;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_out_valid;
    t_rsp               r_out;

    logic               in_acc, rd_en, done_go, full;
    logic [CW-1:0]      eff_limit;
    t_entry             new_entry;
    t_rsp               n_rsp;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        f_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign in_acc  = i_in_valid && o_in_ready;
    assign rd_en   = (r_state == S_SCAN) && (r_left != '0);
    assign done_go = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    assign new_entry = '{source: r_req.source, destination: r_req.destination,
                         timestamp: r_req.timestamp};

    always_comb begin
        eff_limit = CW'(r_limit);
        if (eff_limit == '0) begin
            eff_limit = CW'(1);
        end
        if (eff_limit > CW'(DEPTH)) begin
            eff_limit = CW'(DEPTH);
        end
    end

    assign full = (CW'(r_occ) >= eff_limit);

    always_comb begin
        n_rsp = '0;
        unique case (r_req.command)
            CMD_ADD: begin
                n_rsp.accepted = !r_dup;
            end
            CMD_FWD: begin
                if (r_occ != '0) begin
                    n_rsp.packet_valid    = 1'b1;
                    n_rsp.out_source      = r_fwd.source;
                    n_rsp.out_destination = r_fwd.destination;
                    n_rsp.out_timestamp   = r_fwd.timestamp;
                end
            end
            CMD_COUNT: begin
                n_rsp.match_count = r_cnt;
            end
            default: begin
                n_rsp = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_left == '0 && !r_rd_vld) n_state = S_DONE;
            end
            S_DONE: begin
                if (done_go) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_left      <= '0;
            r_limit     <= LIMIT_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (i_cfg_valid && o_cfg_ready) r_limit <= i_cfg_data;
            if (in_acc) begin
                case (t_cmd'(i_in.command)) inside
                    CMD_ADD, CMD_COUNT: r_left <= r_occ;
                    CMD_FWD:            r_left <= OW'(r_occ != '0);
                    default:            r_left <= '0;
                endcase
            end else if (rd_en) begin
                r_left <= r_left - 1'b1;
            end
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (done_go) begin
                r_out_valid <= 1'b1;
                if (r_req.command == CMD_ADD && !r_dup) begin
                    r_tail <= f_inc(r_tail);
                    if (full) begin
                        r_head <= f_inc(r_head);
                    end else begin
                        r_occ <= r_occ + 1'b1;
                    end
                end else if (r_req.command == CMD_FWD && r_occ != '0) begin
                    r_head <= f_inc(r_head);
                    r_occ  <= r_occ - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= i_in;
            r_ptr <= r_head;
            r_dup <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (rd_en) r_ptr <= f_inc(r_ptr);
            if (r_rd_vld) begin
                if (r_rd_data == new_entry) r_dup <= 1'b1;
                if (r_rd_data.destination == r_req.destination &&
                    r_rd_data.timestamp >= r_req.start_time &&
                    r_rd_data.timestamp <= r_req.end_time) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                r_fwd <= r_rd_data;
            end
        end
        if (done_go) r_out <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd_data <= r_mem[r_ptr];
        if (done_go && r_req.command == CMD_ADD && !r_dup) r_mem[r_tail] <= new_entry;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dfpb_checker.sv =====
// Port-level checker for the deduplicating FIFO packet buffer.
// Bound to dedup_fifo_packet_buffer_unit; depends on dfpb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dfpb_checker
    import dfpb_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire t_rsp               o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("response dropped or changed while stalled");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while one is in flight");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.accepted && o_out.packet_valid))
        else $error("add and forward flags both set");

    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.packet_valid |->
            o_out.out_source == '0 && o_out.out_destination == '0 &&
            o_out.out_timestamp == '0)
        else $error("packet fields set without a forwarded packet");

endmodule

bind dedup_fifo_packet_buffer_unit dfpb_checker u_dfpb_checker (.*);
`default_nettype wire
